FILE: hdl/sha1_hash_engine_macros.svh
// assertion macros shared by the sha1 hash engine checkers
// expects signals named clock and reset in the module that uses them
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

// expression must never hold outside reset
`define SHA1_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("sha1 engine check failed");

// same-cycle implication
`define SHA1_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sha1 engine check failed");

// next-cycle implication
`define SHA1_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sha1 engine check failed");

`endif

FILE: hdl/sha1_pkg.sv
// shared types, constants and helpers of the sha1 hash engine
// used by sha1_round and sha1_hash_engine
`default_nettype none

package sha1_pkg;

   localparam int unsigned ROUNDS = 80;
   localparam int unsigned RND_W  = $clog2(ROUNDS);

   localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);
   localparam logic [RND_W-1:0] RND_GRP1   = RND_W'(20);
   localparam logic [RND_W-1:0] RND_GRP2   = RND_W'(40);
   localparam logic [RND_W-1:0] RND_GRP3   = RND_W'(60);

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK  = 8'h80;
   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] LEN_START = 6'd56;

   localparam int unsigned BLK_W    = 512;
   localparam int unsigned LEN_W    = 64;
   localparam int unsigned RSP_DW   = 40;
   localparam logic [2:0]  LAST_IDX = 3'd4;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } work_type;

   function automatic logic [31:0] iv_word(input logic [2:0] idx);
      logic [31:0] v;
      begin
         unique case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            default: v = 32'hC3D2E1F0;
         endcase
         return v;
      end
   endfunction

endpackage

`default_nettype wire

FILE: hdl/sha1_round.sv
// one sha1 compression round, reused for all 80 rounds
// depends on sha1_pkg for the working-variable struct and round constants
`default_nettype none

module sha1_round (
   input  wire sha1_pkg::work_type           cur_i,
   input  wire logic [31:0]                  w_i,
   input  wire logic [sha1_pkg::RND_W-1:0]   rnd_i,
   output sha1_pkg::work_type                nxt_o
);

   logic [31:0] f;
   logic [31:0] k;
   logic [31:0] t;

   always_comb begin
      if (rnd_i < sha1_pkg::RND_GRP1) begin
         f = (cur_i.b & cur_i.c) | (~cur_i.b & cur_i.d);
         k = sha1_pkg::K0;
      end else if (rnd_i < sha1_pkg::RND_GRP2) begin
         f = cur_i.b ^ cur_i.c ^ cur_i.d;
         k = sha1_pkg::K1;
      end else if (rnd_i < sha1_pkg::RND_GRP3) begin
         f = (cur_i.b & cur_i.c) | (cur_i.b & cur_i.d) | (cur_i.c & cur_i.d);
         k = sha1_pkg::K2;
      end else begin
         f = cur_i.b ^ cur_i.c ^ cur_i.d;
         k = sha1_pkg::K3;
      end
      t = {cur_i.a[26:0], cur_i.a[31:27]} + f + cur_i.e + w_i + k;
      nxt_o.a = t;
      nxt_o.b = cur_i.a;
      nxt_o.c = {cur_i.b[1:0], cur_i.b[31:2]};
      nxt_o.d = cur_i.c;
      nxt_o.e = cur_i.d;
   end

endmodule

`default_nettype wire

FILE: hdl/sha1_hash_engine.sv
// Byte-serial SHA-1 engine. Each accepted data byte is shifted into a 64-byte
// block register; the 64th byte starts a compression that runs one round per
// cycle through the shared round unit and then folds the result into the
// chaining words, during which req_tready is low.
// An item with tlast set pads the message byte by byte through the same path
// (the 0x80 mark byte, zero bytes, then the eight length bytes)
// with one or two more compressions, then presents the digest
// as five 32-bit words, most significant first, one per accepted result item;
// after the fifth word the engine is ready for a new message. Items with
// byte_valid low and tlast low are taken and ignored.
// depends on sha1_pkg and sha1_round
`default_nettype none

module sha1_hash_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] byte_valid
   input  wire logic        req_tlast,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic [sha1_pkg::RSP_DW-1:0] rsp_tdata,  // [31:0] digest_word, [34:32] word_index
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MARK  = 3'd1;
   localparam logic [2:0] S_ZERO  = 3'd2;
   localparam logic [2:0] S_LEN   = 3'd3;
   localparam logic [2:0] S_ROUND = 3'd4;
   localparam logic [2:0] S_ADD   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [2:0]                   ret_ff, ret_in;
   logic [5:0]                   fill_ff, fill_in;
   logic [sha1_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [sha1_pkg::BLK_W-1:0]   blk_ff, blk_in;
   logic [sha1_pkg::RND_W-1:0]   rnd_ff, rnd_in;
   logic [2:0]                   idx_ff, idx_in;
   logic [31:0]                  chain_ff [5];
   logic [31:0]                  chain_in [5];
   sha1_pkg::work_type           work_ff, work_in;
   sha1_pkg::work_type           work_nxt;

   logic        push;
   logic [7:0]  push_byte;
   logic        start;
   logic [31:0] sched_x;
   logic [31:0] sched_w;

   // window holds w[t..t+15], w[t] in the top word
   assign sched_x = blk_ff[95:64] ^ blk_ff[255:224] ^ blk_ff[447:416] ^ blk_ff[511:480];
   assign sched_w = {sched_x[30:0], sched_x[31]};

   sha1_round u_round (
      .cur_i (work_ff),
      .w_i   (blk_ff[511:480]),
      .rnd_i (rnd_ff),
      .nxt_o (work_nxt)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {5'b0, idx_ff, chain_ff[0]};
   assign rsp_tlast  = (idx_ff == sha1_pkg::LAST_IDX);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      fill_in   = fill_ff;
      len_in    = len_ff;
      blk_in    = blk_ff;
      rnd_in    = rnd_ff;
      idx_in    = idx_ff;
      work_in   = work_ff;
      chain_in  = chain_ff;
      push      = 1'b0;
      push_byte = 8'h00;
      start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  push      = 1'b1;
                  push_byte = req_tdata;
                  len_in    = len_ff + sha1_pkg::LEN_W'(8);
               end
               if (req_tuser && fill_ff == sha1_pkg::FILL_LAST) begin
                  start  = 1'b1;
                  ret_in = req_tlast ? S_MARK : S_IDLE;
               end else if (req_tlast) begin
                  state_in = S_MARK;
               end
            end
         end
         S_MARK: begin
            push      = 1'b1;
            push_byte = sha1_pkg::PAD_MARK;
            if (fill_ff == sha1_pkg::FILL_LAST) begin
               start  = 1'b1;
               ret_in = S_ZERO;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if (fill_ff == sha1_pkg::LEN_START) begin
               state_in = S_LEN;
            end else begin
               push = 1'b1;
               if (fill_ff == sha1_pkg::FILL_LAST) begin
                  start  = 1'b1;
                  ret_in = S_ZERO;
               end
            end
         end
         S_LEN: begin
            // length goes out high byte first and is used up by the shift
            push      = 1'b1;
            push_byte = len_ff[63:56];
            len_in    = {len_ff[55:0], 8'h00};
            if (fill_ff == sha1_pkg::FILL_LAST) begin
               start  = 1'b1;
               ret_in = S_OUT;
            end
         end
         S_ROUND: begin
            work_in = work_nxt;
            blk_in  = {blk_ff[479:0], sched_w};
            rnd_in  = rnd_ff + sha1_pkg::RND_W'(1);
            if (rnd_ff == sha1_pkg::LAST_ROUND) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            chain_in[0] = chain_ff[0] + work_ff.a;
            chain_in[1] = chain_ff[1] + work_ff.b;
            chain_in[2] = chain_ff[2] + work_ff.c;
            chain_in[3] = chain_ff[3] + work_ff.d;
            chain_in[4] = chain_ff[4] + work_ff.e;
            state_in    = ret_ff;
         end
         S_OUT: begin
            if (rsp_tready) begin
               // shift digest out and refill with the initial values
               chain_in[0] = chain_ff[1];
               chain_in[1] = chain_ff[2];
               chain_in[2] = chain_ff[3];
               chain_in[3] = chain_ff[4];
               chain_in[4] = sha1_pkg::iv_word(idx_ff);
               if (idx_ff == sha1_pkg::LAST_IDX) begin
                  idx_in   = 3'd0;
                  state_in = S_IDLE;
                  len_in   = '0;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push) begin
         blk_in  = {blk_ff[sha1_pkg::BLK_W-9:0], push_byte};
         fill_in = fill_ff + 6'd1;
      end
      if (start) begin
         state_in  = S_ROUND;
         rnd_in    = '0;
         work_in.a = chain_ff[0];
         work_in.b = chain_ff[1];
         work_in.c = chain_ff[2];
         work_in.d = chain_ff[3];
         work_in.e = chain_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         fill_ff  <= '0;
         len_ff   <= '0;
         rnd_ff   <= '0;
         idx_ff   <= '0;
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= sha1_pkg::iv_word(3'(i));
         end
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      work_ff <= work_in;
   end

endmodule

`default_nettype wire

FILE: hdl/sha1_checker.sv
// port-level checks of the sha1 hash engine, bound to the top level
// depends on sha1_hash_engine_macros.svh and sha1_pkg
`default_nettype none

`include "sha1_hash_engine_macros.svh"

module sha1_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready
);

   logic [2:0] rsp_idx;

   assign rsp_idx = rsp_tdata[34:32];

   // input is closed while the digest is being delivered
   `SHA1_ASSERT_NEVER(a_no_overlap, rsp_tvalid && req_tready)

   `SHA1_ASSERT_IMPL(a_last_on_fifth, rsp_tvalid, rsp_tlast == (rsp_idx == sha1_pkg::LAST_IDX))

   `SHA1_ASSERT_NEXT(a_idx_step, rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid && (rsp_idx == $past(rsp_idx) + 3'd1))

   `SHA1_ASSERT_NEXT(a_done_after_last, rsp_tvalid && rsp_tready && rsp_tlast,
      !rsp_tvalid && req_tready)

   `SHA1_ASSERT_NEXT(a_stall_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for sha1_hash_engine: byte stream in, five digest words out
// depends on sha1_pkg and the engine rtl; carries its own sha-1 model to predict digests

module tb;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 250;
   localparam int PHASE_ITEMS    = 55;
   localparam int NUM_ROWS       = 14;

   localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
   localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

   typedef struct packed {
      logic [7:0]   data;
      logic         valid;
      logic         last;
      logic         known;
      logic [159:0] digest;
   } stim_row_type;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic [7:0]        req_tdata  = '0;   // [7:0] data_byte
   logic              req_tuser  = 1'b0; // [0] byte_valid
   logic              req_tlast  = 1'b0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [sha1_pkg::RSP_DW-1:0] rsp_tdata; // [31:0] digest_word, [34:32] word_index
   logic              rsp_tlast;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;

   // sha-1 model state
   logic [31:0] chain_q [0:4];
   logic [7:0]  block_q [0:63];
   logic [6:0]  fill_q;
   logic [63:0] bit_len_q;

   digest_word_type digest_words_due [$];
   digest_word_type head_word;
   stim_row_type    directed_rows [0:NUM_ROWS-1];

   int tx_idle_pct = 23;
   int rx_idle_pct = 69;
   int error_count = 0;
   int items_sent  = 0;
   int real_items  = 0;
   int messages_done = 0;
   int words_checked = 0;
   int stall_cycles  = 0;

   sha1_hash_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void sha1_compress();
      logic [31:0] w [0:79];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++)
         w[r] = {block_q[4*r], block_q[4*r+1], block_q[4*r+2], block_q[4*r+3]};
      for (int r = 16; r < 80; r++)
         w[r] = rotl32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
      a = chain_q[0];
      b = chain_q[1];
      c = chain_q[2];
      d = chain_q[3];
      e = chain_q[4];
      for (int r = 0; r < sha1_pkg::ROUNDS; r++) begin
         if (r < sha1_pkg::RND_GRP1) begin
            f = (b & c) | (~b & d);
            k = sha1_pkg::K0;
         end else if (r < sha1_pkg::RND_GRP2) begin
            f = b ^ c ^ d;
            k = sha1_pkg::K1;
         end else if (r < sha1_pkg::RND_GRP3) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1_pkg::K2;
         end else begin
            f = b ^ c ^ d;
            k = sha1_pkg::K3;
         end
         t = rotl32(a, 5) + f + e + w[r] + k;
         e = d;
         d = c;
         c = rotl32(b, 30);
         b = a;
         a = t;
      end
      chain_q[0] += a;
      chain_q[1] += b;
      chain_q[2] += c;
      chain_q[3] += d;
      chain_q[4] += e;
   endfunction

   function automatic void model_reset();
      chain_q[0] = 32'h67452301;
      chain_q[1] = 32'hEFCDAB89;
      chain_q[2] = 32'h98BADCFE;
      chain_q[3] = 32'h10325476;
      chain_q[4] = 32'hC3D2E1F0;
      for (int i = 0; i < 64; i++)
         block_q[i] = 8'h00;
      fill_q    = '0;
      bit_len_q = '0;
   endfunction

   // absorbs one item; returns 1 with the digest when the item ends a message
   function automatic bit predict_item(input logic [7:0] data, input logic valid,
                                       input logic last, output logic [159:0] digest);
      digest = '0;
      if (valid) begin
         block_q[fill_q[5:0]] = data;
         fill_q    = fill_q + 7'd1;
         bit_len_q = bit_len_q + 64'd8;
         if (fill_q >= 7'd64) begin
            sha1_compress();
            fill_q = '0;
         end
      end
      if (!last)
         return 1'b0;
      block_q[fill_q[5:0]] = sha1_pkg::PAD_MARK;
      for (int i = int'(fill_q) + 1; i < 64; i++)
         block_q[i] = 8'h00;
      // no room left for the length: it goes into an extra block
      if (fill_q[5:0] >= sha1_pkg::LEN_START) begin
         sha1_compress();
         for (int i = 0; i < 64; i++)
            block_q[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++)
         block_q[56+i] = bit_len_q[63-8*i -: 8];
      sha1_compress();
      digest = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
      model_reset();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("tb: mismatch on %s: got %h, want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // one item on the request side; the digest is queued before the item goes out
   task automatic send_item(input logic [7:0] data, input logic valid, input logic last,
                            input logic known, input logic [159:0] typed);
      logic [159:0] digest;
      bit           ends;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tdata  <= data;
      req_tuser  <= valid;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      ends = predict_item(data, valid, last, digest);
      if (ends) begin
         if (known)
            digest = typed;
         for (int i = 0; i < 5; i++)
            digest_words_due.push_back('{digest[159-32*i -: 32], 3'(i),
                                         3'(i) == sha1_pkg::LAST_IDX});
         messages_done++;
      end
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (valid || last)
         real_items++;
   endtask

   task automatic send_message();
      int len;
      bit tail_empty;
      if ($urandom_range(99) < 25) begin
         // lengths around the padding and block boundaries
         case ($urandom_range(9))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            5: len = 65;
            6: len = 119;
            7: len = 120;
            8: len = 127;
            default: len = 128;
         endcase
      end else begin
         len = $urandom_range(0, 12);
      end
      tail_empty = (len == 0) || ($urandom_range(2) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0)
            send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
         send_item(8'($urandom), 1'b1, !tail_empty && (i == len - 1), 1'b0, '0);
      end
      if (tail_empty)
         send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      while (digest_words_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct);
      int start;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS)
         send_message();
      pause_until_drained();
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_words_due.size() == 0) begin
            report_mismatch("unexpected digest word", rsp_tdata[31:0], '0);
         end else begin
            head_word = digest_words_due.pop_front();
            if (rsp_tdata[31:0] !== head_word.word)
               report_mismatch("digest_word", rsp_tdata[31:0], head_word.word);
            if (rsp_tdata[34:32] !== head_word.index)
               report_mismatch("word_index", 32'(rsp_tdata[34:32]), 32'(head_word.index));
            if (rsp_tlast !== head_word.last)
               report_mismatch("last_word", 32'(rsp_tlast), 32'(head_word.last));
            words_checked++;
         end
      end
   end

   // ends the run when neither side moves an item for too long
   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("tb: timeout, %0d digest words still due", digest_words_due.size());
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      // data, byte_valid, last, digest known, digest
      directed_rows[0]  = '{8'h00, 1'b0, 1'b0, 1'b0, '0};           // idle item
      directed_rows[1]  = '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}; // empty message
      directed_rows[2]  = '{8'h61, 1'b1, 1'b0, 1'b0, '0};
      directed_rows[3]  = '{8'h62, 1'b1, 1'b0, 1'b0, '0};
      directed_rows[4]  = '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST};
      directed_rows[5]  = '{8'h00, 1'b1, 1'b1, 1'b0, '0};
      directed_rows[6]  = '{8'hFF, 1'b1, 1'b1, 1'b0, '0};
      directed_rows[7]  = '{8'hA5, 1'b0, 1'b0, 1'b0, '0};           // ignored byte
      directed_rows[8]  = '{8'h5A, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST};
      directed_rows[9]  = '{8'h78, 1'b1, 1'b0, 1'b0, '0};
      directed_rows[10] = '{8'hC3, 1'b0, 1'b0, 1'b0, '0};           // idle mid-message
      directed_rows[11] = '{8'h3C, 1'b0, 1'b1, 1'b0, '0};           // empty tail
      directed_rows[12] = '{8'h55, 1'b1, 1'b0, 1'b0, '0};
      directed_rows[13] = '{8'hAA, 1'b1, 1'b1, 1'b0, '0};
      model_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < NUM_ROWS; n++)
         send_item(directed_rows[n].data, directed_rows[n].valid, directed_rows[n].last,
                   directed_rows[n].known, directed_rows[n].digest);
      pause_until_drained();

      run_phase(23, 69);
      run_phase(69, 23);
      run_phase(0, 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d items sent (%0d carrying data or end), %0d messages hashed",
               items_sent, real_items, messages_done);
      $display("tb: %0d digest words checked across sender, receiver and no-stall pacing",
               words_checked);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/sha1_pkg.sv
hdl/sha1_round.sv
hdl/sha1_hash_engine.sv
hdl/sha1_checker.sv
verif/tb.sv
